/* rtl/wqbp_pkg.sv */
// ----------------------------------------------------------------------------
// wqbp_pkg
// Shared types, constants and packing function for the weight quantizer.
// ----------------------------------------------------------------------------
package wqbp_pkg;

    localparam int VALUES_PER_BLOCK = 32;
    localparam int LANE_W           = $clog2(VALUES_PER_BLOCK);
    localparam int NUM_W            = 41;
    localparam int DIV_W            = 40;
    localparam int Q_W              = 9;
    localparam int MAX_WORDS        = 8;
    localparam int WIDX_W           = $clog2(MAX_WORDS);

    localparam logic [1:0] WCODE_2 = 2'd0;
    localparam logic [1:0] WCODE_3 = 2'd1;
    localparam logic [1:0] WCODE_4 = 2'd2;
    localparam logic [1:0] WCODE_8 = 2'd3;
    localparam logic [1:0] WCODE_RESET = WCODE_4;

    localparam logic ADDR_WIDTH_CODE = 1'b0;

    typedef struct packed {
        logic             vld;
        logic             kind;
        logic [1:0]       wcode;
        logic [7:0]       zp;
        logic             sat;
        logic             zer;
        logic [NUM_W-1:0] rem;
        logic [DIV_W-1:0] d;
        logic [31:0]      s;
        logic [Q_W-1:0]   q;
    } t_cell;

    typedef logic [MAX_WORDS-1:0][31:0] t_words;
    typedef logic [VALUES_PER_BLOCK-1:0][7:0] t_vals;

    function automatic logic [7:0] max_q(input logic [1:0] wcode);
        logic [7:0] m;
        case (wcode)
            WCODE_2: m = 8'd3;
            WCODE_3: m = 8'd7;
            WCODE_4: m = 8'd15;
            default: m = 8'd255;
        endcase
        return m;
    endfunction

    function automatic logic [WIDX_W-1:0] last_word(input logic [1:0] wcode);
        logic [WIDX_W-1:0] c;
        case (wcode)
            WCODE_2: c = WIDX_W'(1);
            WCODE_3: c = WIDX_W'(2);
            WCODE_4: c = WIDX_W'(3);
            default: c = WIDX_W'(7);
        endcase
        return c;
    endfunction

    function automatic t_words pack_block(input t_vals v, input logic [1:0] wcode);
        t_words     w;
        logic [63:0] acc;
        int         per;
        int         bits;
        w = '0;
        case (wcode)
            WCODE_2: begin per = 16; bits = 2; end
            WCODE_4: begin per = 8;  bits = 4; end
            default: begin per = 4;  bits = 8; end
        endcase
        if (wcode == WCODE_3) begin
            acc = '0;
            for (int j = 0; j < 10; j++) acc |= 64'(v[j]) << (3 * j);
            acc |= 64'(v[10]) << 30;
            w[0] = acc[31:0];
            acc = '0;
            for (int j = 0; j < 10; j++) acc |= 64'(v[11 + j]) << (3 * j + 1);
            acc |= 64'(v[10][2]);
            acc |= 64'(v[21]) << 31;
            w[1] = acc[31:0];
            acc = '0;
            for (int j = 0; j < 10; j++) acc |= 64'(v[22 + j]) << (3 * j + 2);
            acc |= 64'(v[21][2:1]);
            w[2] = acc[31:0];
        end else begin
            for (int k = 0; k < MAX_WORDS; k++) begin
                acc = '0;
                for (int j = 0; j < 16; j++) begin
                    if (j < per && k * per + j < VALUES_PER_BLOCK)
                        acc |= 64'(v[(k * per + j) % VALUES_PER_BLOCK]) << (bits * j);
                end
                w[k] = acc[31:0];
            end
        end
        return w;
    endfunction

endpackage

/* rtl/wqbp_div_cell.sv */
// ----------------------------------------------------------------------------
// wqbp_div_cell
// One restoring-division cell: settles one quotient bit and hands on.
// ----------------------------------------------------------------------------
module wqbp_div_cell import wqbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_c,
    output t_cell o_c
);

    t_cell r_c;
    t_cell n_c;
    logic  ge;

    always_comb begin
        ge  = i_c.rem >= {1'b0, i_c.d};
        n_c = i_c;
        if (ge) n_c.rem = i_c.rem - {1'b0, i_c.d};
        n_c.q = {i_c.q[Q_W-2:0], ge};
        n_c.d = i_c.d >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

/* rtl/wqbp_pack.sv */
// ----------------------------------------------------------------------------
// wqbp_pack
// Collects 32 values and emits the packed words of each full block.
// ----------------------------------------------------------------------------
module wqbp_pack import wqbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [7:0]  i_val,
    input  logic [1:0]  i_wcode,
    output logic        o_stall,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // packed_word
    output logic        o_m_tlast
);

    logic [7:0]        r_buf [VALUES_PER_BLOCK];
    logic [LANE_W-1:0] r_lane;
    t_words            r_pack;
    logic              r_busy;
    logic [WIDX_W-1:0] r_idx;
    logic [WIDX_W-1:0] r_last;
    t_vals             blk;
    logic              complete;
    logic              take;

    always_comb begin
        for (int i = 0; i < VALUES_PER_BLOCK - 1; i++) blk[i] = r_buf[i];
        blk[VALUES_PER_BLOCK-1] = i_val;
    end

    assign complete = i_vld && (r_lane == LANE_W'(VALUES_PER_BLOCK - 1));
    assign o_stall  = complete && r_busy;
    assign take     = i_vld && !o_stall;

    always_ff @(posedge i_clk) begin
        if (take) r_buf[r_lane] <= i_val;
        if (take && complete) begin
            r_pack <= pack_block(blk, i_wcode);
            r_last <= last_word(i_wcode);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (take) r_lane <= r_lane + 1'b1;
            if (take && complete) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && i_m_tready) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == r_last) r_busy <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = r_pack[r_idx];
    assign o_m_tlast  = (r_idx == r_last);

endmodule

/* rtl/weight_quantize_bit_pack.sv */
// ----------------------------------------------------------------------------
// weight_quantize_bit_pack
// Quantizes Q16.16 weights by group scale and zero point and packs 32 values
// into 2, 3, 4 or 8 words of 32 bits.
// ----------------------------------------------------------------------------
// One item is taken per cycle when not stalled. Each weight runs through a
// multiply stage and a chain of nine division cells (one quotient bit each),
// with the numerator formed ahead of the first cell and the rounding done after
// the last; its value passes the input and cell registers into the block buffer.
// When a block fills, its words leave one per cycle while the output is ready;
// input stalls only if another block completes before the last has fully left.
// ----------------------------------------------------------------------------
module weight_quantize_bit_pack import wqbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,    // weight, scale, zero_point
    input  logic        i_s_tuser,    // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // packed_word
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_wcode;
    logic        adv;
    logic        stall;

    logic        r_a_vld;
    logic        r_a_kind;
    logic [1:0]  r_a_wcode;
    logic [7:0]  r_a_zp;
    logic [31:0] r_a_w;
    logic [31:0] r_a_s;
    logic [39:0] r_a_prod;
    logic [31:0] s_eff;

    logic signed [41:0] num;
    t_cell       c_in;
    t_cell       c [Q_W+1];

    logic [Q_W:0] q_rnd;
    logic [31:0]  r_lo;
    logic         rnd;
    logic [7:0]   val;
    logic [7:0]   mq;

    assign pready = 1'b1;
    assign prdata = {30'd0, r_wcode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcode <= WCODE_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_WIDTH_CODE) begin
            r_wcode <= pwdata[1:0];
        end
    end

    assign adv        = !stall;
    assign o_s_tready = adv;
    assign s_eff      = (i_s_tdata[63:32] == 32'd0) ? 32'd1 : i_s_tdata[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_kind  <= i_s_tuser;
            r_a_wcode <= r_wcode;
            r_a_zp    <= i_s_tdata[71:64];
            r_a_w     <= i_s_tdata[31:0];
            r_a_s     <= s_eff;
            r_a_prod  <= i_s_tdata[71:64] * s_eff;
        end
    end

    always_comb begin
        num        = $signed({{10{r_a_w[31]}}, r_a_w}) + $signed({2'b00, r_a_prod});
        c_in       = '0;
        c_in.vld   = r_a_vld;
        c_in.kind  = r_a_kind;
        c_in.wcode = r_a_wcode;
        c_in.zp    = r_a_zp;
        c_in.zer   = (num <= 0);
        c_in.rem   = num[NUM_W-1:0];
        c_in.sat   = ({1'b0, num[NUM_W-1:0]} >= {r_a_s, 10'd0} >> 1);
        c_in.d     = {r_a_s, 8'd0};
        c_in.s     = r_a_s;
    end

    assign c[0] = c_in;

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        wqbp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_c     (c[g]),
            .o_c     (c[g+1])
        );
    end

    always_comb begin
        r_lo  = c[Q_W].rem[31:0];
        rnd   = ({r_lo, 1'b0} > {1'b0, c[Q_W].s})
             || (({r_lo, 1'b0} == {1'b0, c[Q_W].s}) && c[Q_W].q[0]);
        q_rnd = {1'b0, c[Q_W].q} + (Q_W+1)'(rnd);
        mq    = max_q(c[Q_W].wcode);
        if (c[Q_W].kind)               val = c[Q_W].zp;
        else if (c[Q_W].zer)           val = 8'd0;
        else if (c[Q_W].sat)           val = mq;
        else if (q_rnd > {2'b00, mq})  val = mq;
        else                           val = q_rnd[7:0];
    end

    wqbp_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (c[Q_W].vld),
        .i_val      (val),
        .i_wcode    (c[Q_W].wcode),
        .o_stall    (stall),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
